### src/space_split_token_classifier_unit_assert.svh
// Assertion macros for the space-split token classifier.
// Each macro takes a label, a condition and a consequence, and needs clk and rst_n in scope.
`ifndef SPACE_SPLIT_TOKEN_CLASSIFIER_UNIT_ASSERT_SVH
`define SPACE_SPLIT_TOKEN_CLASSIFIER_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define SSTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define SSTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sstc_pkg.sv
// Shared constants and types of the space-split token classifier.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package sstc_pkg;

  localparam int MAX_LINE   = 4096;
  localparam int POS_W      = $clog2(MAX_LINE);
  localparam int LEN_W      = POS_W + 1;
  localparam int CLASS_W    = 5;
  localparam int NUM_KW     = 13;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [CLASS_W-1:0] CLS_NAME    = 5'd13;
  localparam logic [CLASS_W-1:0] CLS_NUMERAL = 5'd14;
  localparam logic [CLASS_W-1:0] CLS_ERROR   = 5'd15;
  localparam logic [CLASS_W-1:0] CLS_EMPTY   = 5'd16;
  localparam logic [CLASS_W-1:0] CLS_END     = 5'd17;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Keyword bytes, first byte in the low bits, unused upper bytes zero.
  localparam logic [31:0] KW_TEXT [NUM_KW] = '{
    32'h2174_6567,  // get!
    32'h2163_7470,  // ptc!
    32'h0000_003D,  // =
    32'h0000_002B,  // +
    32'h0000_002D,  // -
    32'h0000_002A,  // *
    32'h0000_2A2A,  // **
    32'h0000_002F,  // /
    32'h0000_0028,  // (
    32'h0000_0029,  // )
    32'h0000_3D2B,  // +=
    32'h2164_6D63,  // cmd!
    32'h0000_2F2F   // //
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd4, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd4, 3'd2
  };

  typedef struct packed {
    logic [CLASS_W-1:0] token_class;
    logic [POS_W-1:0]   word_start;
    logic [LEN_W-1:0]   word_length;
    logic               is_last;
  } token_t;

endpackage

### src/sstc_if.sv
// Channel interfaces of the space-split token classifier: byte input and token output.
// Depends on sstc_pkg for the field widths.
`timescale 1ns / 1ps

interface sstc_in_if
  import sstc_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_valid;
  logic       line_end;

  modport source (output valid, char_code, char_valid, line_end, input ready);
  modport sink (input valid, char_code, char_valid, line_end, output ready);
endinterface

interface sstc_out_if
  import sstc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] token_class;
  logic [POS_W-1:0]   word_start;
  logic [LEN_W-1:0]   word_length;
  logic               is_last;

  modport source (output valid, token_class, word_start, word_length, is_last, input ready);
  modport sink (input valid, token_class, word_start, word_length, is_last, output ready);
endinterface

### src/space_split_token_classifier_unit.sv
// Space-split token classifier: splits a byte stream at spaces and classifies each word.
// Usage: in_beat carries one byte (or a bare end marker) per beat, with a line-end flag.
// out_beat carries one token per beat: class, word start, word length and is_last.
// A word closes on a space or at line end; a line end also yields an empty-line token
// when the line held no word, followed by an end token with is_last set.
// The word state and line position update in the cycle a beat is accepted, and the
// tokens it causes enter a four-entry output queue in the same cycle.
// Throughput: one input beat per cycle while each beat yields at most one token and the
// receiver does not stall. The output moves one token per cycle, so a beat that yields
// two tokens leaves as two output beats; in_ready is high only while the queue has two
// free entries. When the receiver stalls, tokens stay in the queue in order and in_ready
// drops once the queue cannot take two more tokens; nothing is lost or repeated.
// Reset (synchronous, active low) empties the queue and returns the word and line
// state to the start of a line.
// Depends on sstc_pkg, the channel interfaces in sstc_if.sv and the assertion macros.
`timescale 1ns / 1ps
`include "space_split_token_classifier_unit_assert.svh"

module space_split_token_classifier_unit
  import sstc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sstc_in_if.sink           in_beat,
  sstc_out_if.source        out_beat
);

  logic [31:0]      head_r, head_nxt, head_a;
  logic [LEN_W-1:0] len_r, len_nxt, len_a;
  logic             letters_r, letters_nxt, letters_a;
  logic             numeric_r, numeric_nxt, numeric_a;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] start_r, start_nxt, start_a;
  logic             had_r, had_nxt, had_a;

  token_t           fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  logic [7:0]       ch;
  logic             accept, pop, is_space, is_char, is_letter, is_numer, line_end;
  logic             word_emit, empty_emit;
  logic [31:0]      tok_head;
  logic [LEN_W-1:0] tok_len;
  logic [POS_W-1:0] tok_start;
  logic             tok_letters, tok_numeric;
  logic [CLASS_W-1:0] tok_class;
  token_t           res0, res1, word_tok, empty_tok, end_tok;
  logic [1:0]       n_push;

  assign accept   = in_beat.valid && in_beat.ready;
  assign pop      = out_beat.valid && out_beat.ready;
  assign ch       = in_beat.char_code;
  assign line_end = in_beat.line_end;
  assign is_space = in_beat.char_valid && (ch == CHAR_SPACE);
  assign is_char  = in_beat.char_valid && (ch != CHAR_SPACE);

  assign is_letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A)
                     || (ch == 8'h5F);
  assign is_numer  = (ch >= 8'h30 && ch <= 8'h39) || (ch == 8'h2E) || (ch == 8'h2D)
                     || (ch == 8'h2B);

  // Word state after taking a non-space byte.
  always_comb begin
    head_a = head_r;
    if (len_r < LEN_W'(4)) begin
      case (len_r[1:0])
        2'd0:    head_a[7:0]   = ch;
        2'd1:    head_a[15:8]  = ch;
        2'd2:    head_a[23:16] = ch;
        default: head_a[31:24] = ch;
      endcase
    end
    len_a     = (len_r < LEN_W'(MAX_LINE)) ? len_r + LEN_W'(1) : len_r;
    letters_a = letters_r && is_letter;
    numeric_a = numeric_r && is_numer;
    start_a   = (len_r == '0) ? pos_r : start_r;
    had_a     = had_r || is_char;
  end

  // The token closed by a space uses the word as it stood; otherwise the updated word.
  always_comb begin
    if (is_char) begin
      tok_head    = head_a;
      tok_len     = len_a;
      tok_start   = start_a;
      tok_letters = letters_a;
      tok_numeric = numeric_a;
    end else begin
      tok_head    = head_r;
      tok_len     = len_r;
      tok_start   = start_r;
      tok_letters = letters_r;
      tok_numeric = numeric_r;
    end
  end

  always_comb begin
    if (tok_letters) begin
      tok_class = CLS_NAME;
    end else if (tok_numeric) begin
      tok_class = CLS_NUMERAL;
    end else begin
      tok_class = CLS_ERROR;
    end
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      if (tok_len == LEN_W'(KW_LEN[i]) && tok_head == KW_TEXT[i]) begin
        tok_class = CLASS_W'(i);
      end
    end
  end

  assign word_emit  = (is_space && len_r != '0) || (line_end && is_char)
                      || (line_end && !in_beat.char_valid && len_r != '0);
  assign empty_emit = line_end && !had_a;

  always_comb begin
    word_tok  = '{token_class: tok_class, word_start: tok_start, word_length: tok_len,
                  is_last: 1'b0};
    empty_tok = '{token_class: CLS_EMPTY, word_start: '0, word_length: '0, is_last: 1'b0};
    end_tok   = '{token_class: CLS_END, word_start: '0, word_length: '0, is_last: 1'b1};
    res1      = end_tok;
    if (word_emit) begin
      res0 = word_tok;
    end else if (empty_emit) begin
      res0 = empty_tok;
    end else begin
      res0 = end_tok;
    end
    n_push = 2'(word_emit) + 2'(empty_emit) + 2'(line_end);
  end

  always_comb begin
    head_nxt    = head_r;
    len_nxt     = len_r;
    letters_nxt = letters_r;
    numeric_nxt = numeric_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    had_nxt     = had_r;
    if (accept) begin
      if (line_end) begin
        head_nxt    = '0;
        len_nxt     = '0;
        letters_nxt = 1'b1;
        numeric_nxt = 1'b1;
        pos_nxt     = '0;
        start_nxt   = '0;
        had_nxt     = 1'b0;
      end else if (is_space) begin
        head_nxt    = '0;
        len_nxt     = '0;
        letters_nxt = 1'b1;
        numeric_nxt = 1'b1;
        start_nxt   = '0;
      end else if (is_char) begin
        head_nxt    = head_a;
        len_nxt     = len_a;
        letters_nxt = letters_a;
        numeric_nxt = numeric_a;
        start_nxt   = start_a;
        had_nxt     = had_a;
      end
      if (!line_end && in_beat.char_valid && pos_r < POS_W'(MAX_LINE - 1)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      len_r     <= '0;
      letters_r <= 1'b1;
      numeric_r <= 1'b1;
      pos_r     <= '0;
      start_r   <= '0;
      had_r     <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      len_r     <= len_nxt;
      letters_r <= letters_nxt;
      numeric_r <= numeric_nxt;
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      had_r     <= had_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (accept && n_push == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + (accept ? CNT_W'(n_push) : CNT_W'(0)) - CNT_W'(pop);
    end
  end

  assign in_beat.ready        = cnt_r <= CNT_W'(FIFO_DEPTH - 2);
  assign out_beat.valid       = cnt_r != '0;
  assign out_beat.token_class = fifo_r[rd_ptr_r].token_class;
  assign out_beat.word_start  = fifo_r[rd_ptr_r].word_start;
  assign out_beat.word_length = fifo_r[rd_ptr_r].word_length;
  assign out_beat.is_last     = fifo_r[rd_ptr_r].is_last;

  `SSTC_ASSERT_NOW(a_queue_bound, 1'b1, cnt_r <= CNT_W'(FIFO_DEPTH),
    "Output queue holds more tokens than it has entries.")
  `SSTC_ASSERT_NEXT(a_line_reset, accept && line_end,
    pos_r == '0 && len_r == '0 && !had_r,
    "Line state was not cleared after a line end.")
  `SSTC_ASSERT_NOW(a_last_is_end, out_beat.valid && out_beat.is_last,
    out_beat.token_class == CLS_END,
    "A token marked last is not an end token.")

endmodule

### bench/space_split_token_classifier_unit_tb.sv
// Testbench for the space-split token classifier: drives byte beats and checks every token.
// A behavioral predictor builds the expected tokens; depends on sstc_pkg and sstc_if.sv.
`timescale 1ns / 1ps

module space_split_token_classifier_unit_tb;
  import sstc_pkg::*;

  localparam int    HALF_PERIOD = 6;
  localparam int    LIMIT_NS    = 10_000_000;
  localparam int    DRAIN_LIMIT = 10_000;
  localparam string NAME_CHARS  = "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string NUM_CHARS   = "0123456789.-+";
  localparam string TAIL_CHARS  = "!=*/+(";

  logic clk;
  logic rst_n;

  sstc_in_if  in_ch ();
  sstc_out_if out_ch ();

  space_split_token_classifier_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch)
  );

  token_t      pending_tokens[$];
  logic [7:0]  line_bytes[$];
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          failed;
  int          beats_counted;
  int          lines_done;
  int          tokens_checked;

  logic [31:0] word_bytes;
  int          word_len;
  bit          only_letters;
  bit          only_numeric;
  int          line_pos;
  int          word_start_pos;
  bit          line_has_word;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  initial begin
    #LIMIT_NS;
    $display("simulation failed");
    $finish;
  end

  function automatic void clear_word();
    word_bytes     = '0;
    word_len       = 0;
    only_letters   = 1'b1;
    only_numeric   = 1'b1;
    word_start_pos = 0;
  endfunction

  function automatic void clear_line();
    clear_word();
    line_pos      = 0;
    line_has_word = 1'b0;
  endfunction

  function automatic void push_token(logic [CLASS_W-1:0] cls, int start, int len, logic last);
    token_t t;
    t.token_class = cls;
    t.word_start  = POS_W'(start);
    t.word_length = LEN_W'(len);
    t.is_last     = last;
    pending_tokens = {pending_tokens, t};
  endfunction

  function automatic void add_byte(logic [7:0] b);
    line_bytes = {line_bytes, b};
  endfunction

  function automatic logic [CLASS_W-1:0] classify_word();
    for (int i = 0; i < NUM_KW; i++) begin
      if (int'(KW_LEN[i]) == word_len && KW_TEXT[i] == word_bytes) return CLASS_W'(i);
    end
    if (only_letters) return CLS_NAME;
    if (only_numeric) return CLS_NUMERAL;
    return CLS_ERROR;
  endfunction

  function automatic void close_word();
    push_token(classify_word(), word_start_pos, word_len, 1'b0);
    clear_word();
  endfunction

  function automatic void predict_tokens(logic [7:0] code, logic cv, logic le);
    bit is_letter;
    bit is_num;
    if (cv) begin
      if (code == CHAR_SPACE) begin
        if (word_len > 0) close_word();
      end else begin
        is_letter = (code >= "a" && code <= "z") || (code >= "A" && code <= "Z") || code == "_";
        is_num    = (code >= "0" && code <= "9") || code == "." || code == "-" || code == "+";
        if (word_len == 0) begin
          word_start_pos = line_pos;
          line_has_word  = 1'b1;
        end
        if (word_len < 4) word_bytes[8*word_len +: 8] = code;
        if (!is_letter) only_letters = 1'b0;
        if (!is_num) only_numeric = 1'b0;
        if (word_len < MAX_LINE) word_len++;
      end
      if (line_pos < MAX_LINE - 1) line_pos++;
    end
    if (le) begin
      if (word_len > 0) close_word();
      if (!line_has_word) push_token(CLS_EMPTY, 0, 0, 1'b0);
      push_token(CLS_END, 0, 0, 1'b1);
      clear_line();
      lines_done++;
    end
  endfunction

  // Result side: check each accepted token, then pick the next ready value.
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tokens_checked++;
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: class %0d start %0d length %0d last %0d",
               out_ch.token_class, out_ch.word_start, out_ch.word_length, out_ch.is_last);
        failed = 1'b1;
      end else begin
        want = pending_tokens.pop_front();
        if (out_ch.token_class !== want.token_class) begin
          $error("token_class mismatch: expected %0d, actual %0d",
                 want.token_class, out_ch.token_class);
          failed = 1'b1;
        end
        if (out_ch.word_start !== want.word_start) begin
          $error("word_start mismatch: expected %0d, actual %0d",
                 want.word_start, out_ch.word_start);
          failed = 1'b1;
        end
        if (out_ch.word_length !== want.word_length) begin
          $error("word_length mismatch: expected %0d, actual %0d",
                 want.word_length, out_ch.word_length);
          failed = 1'b1;
        end
        if (out_ch.is_last !== want.is_last) begin
          $error("is_last mismatch: expected %0d, actual %0d", want.is_last, out_ch.is_last);
          failed = 1'b1;
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_beat(input logic [7:0] code, input logic cv, input logic le);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_code  <= code;
    in_ch.char_valid <= cv;
    in_ch.line_end   <= le;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tokens(code, cv, le);
    if (cv || le) beats_counted++;
  endtask

  task automatic send_text(input string s, input bit end_on_last);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b1, end_on_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void add_word();
    int         kw;
    int         n;
    logic [7:0] c;
    kw = $urandom_range(0, NUM_KW - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        for (int i = 0; i < KW_LEN[kw]; i++) add_byte(KW_TEXT[kw][8*i +: 8]);
      end
      3: begin
        // A keyword with its last byte dropped or one byte too many.
        n = KW_LEN[kw];
        if (n > 1 && $urandom_range(0, 1)) n--;
        for (int i = 0; i < n; i++) add_byte(KW_TEXT[kw][8*i +: 8]);
        if (n == KW_LEN[kw]) add_byte(pick_char(TAIL_CHARS));
      end
      4, 5: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        repeat (n) add_byte(pick_char(NAME_CHARS));
      end
      6, 7: begin
        n = $urandom_range(1, 6);
        repeat (n) add_byte(pick_char(NUM_CHARS));
      end
      8: begin
        n = $urandom_range(2, 6);
        repeat (n) add_byte($urandom_range(0, 1) ? pick_char(NAME_CHARS)
                                                 : pick_char(NUM_CHARS));
      end
      default: begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255)); while (c == CHAR_SPACE);
          add_byte(c);
        end
      end
    endcase
  endfunction

  task automatic send_random_line();
    int words;
    int ending;
    line_bytes.delete();
    words  = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 5);
    ending = $urandom_range(0, 2);
    repeat ($urandom_range(0, 2)) add_byte(CHAR_SPACE);
    for (int w = 0; w < words; w++) begin
      if (w > 0) repeat ($urandom_range(1, 3)) add_byte(CHAR_SPACE);
      add_word();
    end
    if (ending == 1) repeat ($urandom_range(1, 2)) add_byte(CHAR_SPACE);
    if (line_bytes.size() == 0) ending = 2;
    foreach (line_bytes[i]) begin
      if ($urandom_range(0, 99) < 3) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(line_bytes[i], 1'b1, ending != 2 && i == line_bytes.size() - 1);
    end
    if (ending == 2) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic run_random_lines(input int beats);
    int first;
    first = beats_counted;
    while (beats_counted - first < beats) send_random_line();
  endtask

  // Each keyword alone on a line, closed by the line end on its last byte.
  task automatic test_keywords();
    for (int k = 0; k < NUM_KW; k++) begin
      for (int i = 0; i < KW_LEN[k]; i++) begin
        send_beat(KW_TEXT[k][8*i +: 8], 1'b1, i == KW_LEN[k] - 1);
      end
    end
  endtask

  task automatic test_special_cases();
    send_beat(8'hFF, 1'b0, 1'b0);
    send_text(" Az_  0.9+- ", 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_text(" a1", 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hAA, 1'b0, 1'b1);
    send_text("  ", 1'b1);
  endtask

  // A word longer than the line limit, then words past the saturated position.
  task automatic test_long_line();
    send_text("ab ", 1'b0);
    repeat (MAX_LINE + 200) send_beat("x", 1'b1, 1'b0);
    send_text("5 7 q", 1'b1);
  endtask

  initial begin
    int drain;
    failed         = 1'b0;
    beats_counted  = 0;
    lines_done     = 0;
    tokens_checked = 0;
    tx_idle_pct    = 28;
    rx_idle_pct    = 63;
    clear_line();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = '0;
    in_ch.char_valid = 1'b0;
    in_ch.line_end   = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keywords();
    test_special_cases();
    run_random_lines(517);
    tx_idle_pct = 63;
    rx_idle_pct = 28;
    test_long_line();
    run_random_lines(517);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_lines(516);
    in_ch.valid <= 1'b0;

    drain = 0;
    while (pending_tokens.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", pending_tokens.size());
      failed = 1'b1;
    end

    $display("Sent %0d beats in %0d lines, including a line past the length limit.",
             beats_counted, lines_done);
    $display("Checked %0d tokens under three sender and receiver stall mixes.", tokens_checked);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
